// ===== design/voice_lifetime_tracker_macros.svh =====
// assertion macros for the voice lifetime tracker
`ifndef VOICE_LIFETIME_TRACKER_MACROS_SVH
`define VOICE_LIFETIME_TRACKER_MACROS_SVH
`ifndef ASSERT_OFF
`define VLT_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);
`define VLT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) !(cond)) else $error(msg);
`else
`define VLT_ASSERT(lbl, prop, msg)
`define VLT_NEVER(lbl, cond, msg)
`endif
`endif

// ===== design/vlt_pkg.sv =====
// shared types and constants for the voice lifetime tracker
package vlt_pkg;

    localparam int VOICE_SLOTS  = 32;
    localparam int SLOT_W       = $clog2(VOICE_SLOTS);

    localparam int HANDLE_W     = 31;
    localparam int TICK_W       = 31;
    localparam int END_W        = 32;
    localparam int LEN_W        = 16;
    localparam int PITCH_W      = 8;
    localparam int RATE_W       = 10;
    localparam int CMD_W        = 2;

    localparam int HEADER_BYTES = 8;
    localparam int SAMPLE_RATE  = 11025;
    localparam int PITCH_SHIFT  = 7;
    localparam int RATE_RESET   = 35;

    localparam int SCALED_W     = LEN_W + PITCH_SHIFT;
    localparam int PROD_W       = SCALED_W + RATE_W;
    localparam int QT_W         = 20;

    localparam int DVD_W        = PROD_W;
    localparam int REM_W        = $clog2(SAMPLE_RATE + 1);
    localparam int CNT_W        = $clog2(DVD_W + 1);
    localparam int MCNT_W       = $clog2(RATE_W + 1);

    typedef enum logic [CMD_W-1:0] {
        CMD_START = 2'd0,
        CMD_STOP  = 2'd1,
        CMD_QUERY = 2'd2
    } vlt_cmd_t;

    typedef struct packed {
        logic [DVD_W-1:0] dividend;
        logic [REM_W-1:0] rem_init;
        logic [REM_W-1:0] divisor;
        logic [CNT_W-1:0] steps;
    } vlt_div_req_t;

    typedef struct packed {
        logic                entry;
        logic                stop;
        logic [SLOT_W-1:0]   addr;
        logic [HANDLE_W-1:0] handle;
        logic [END_W-1:0]    expiry;
    } vlt_slot_wr_t;

    typedef struct packed {
        logic [HANDLE_W-1:0] handle;
        logic [END_W-1:0]    expiry;
        logic                stopped;
    } vlt_slot_rd_t;

endpackage

// ===== design/vlt_serial_div.sv =====
// bit-serial restoring divider, one quotient bit per cycle
module vlt_serial_div (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             start,
    input  vlt_pkg::vlt_div_req_t            req,
    output logic                             busy,
    output logic                             done,
    output logic [vlt_pkg::DVD_W-1:0]        dvd,
    output logic [vlt_pkg::REM_W-1:0]        rem
);

    logic [vlt_pkg::DVD_W-1:0] dvd_reg;
    logic [vlt_pkg::REM_W-1:0] rem_reg;
    logic [vlt_pkg::REM_W-1:0] dvs_reg;
    logic [vlt_pkg::CNT_W-1:0] cnt_reg;
    logic                      busy_reg;
    logic                      done_reg;

    logic [vlt_pkg::REM_W+1:0] diff;
    logic [vlt_pkg::REM_W:0]   trial;
    logic                      ge;

    assign trial = {rem_reg, dvd_reg[vlt_pkg::DVD_W-1]};
    assign diff  = {1'b0, trial} - {2'b00, dvs_reg};
    assign ge    = !diff[vlt_pkg::REM_W+1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                dvd_reg  <= req.dividend;
                rem_reg  <= req.rem_init;
                dvs_reg  <= req.divisor;
                cnt_reg  <= req.steps;
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                dvd_reg <= {dvd_reg[vlt_pkg::DVD_W-2:0], ge};
                rem_reg <= ge ? diff[vlt_pkg::REM_W-1:0] : trial[vlt_pkg::REM_W-1:0];
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == vlt_pkg::CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign dvd  = dvd_reg;
    assign rem  = rem_reg;

endmodule

// ===== design/vlt_serial_mul.sv =====
// bit-serial shift-add multiplier, one multiplier bit per cycle
module vlt_serial_mul (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [vlt_pkg::SCALED_W-1:0]  a,
    input  logic [vlt_pkg::RATE_W-1:0]    b,
    output logic                          done,
    output logic [vlt_pkg::PROD_W-1:0]    prod
);

    logic [vlt_pkg::PROD_W-1:0]   acc_reg;
    logic [vlt_pkg::SCALED_W-1:0] a_reg;
    logic [vlt_pkg::RATE_W-1:0]   b_reg;
    logic [vlt_pkg::MCNT_W-1:0]   cnt_reg;
    logic                         busy_reg;
    logic                         done_reg;

    logic [vlt_pkg::PROD_W-1:0]   addend;

    assign addend = b_reg[vlt_pkg::RATE_W-1] ? vlt_pkg::PROD_W'(a_reg) : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                acc_reg  <= '0;
                a_reg    <= a;
                b_reg    <= b;
                cnt_reg  <= vlt_pkg::MCNT_W'(vlt_pkg::RATE_W);
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                acc_reg <= {acc_reg[vlt_pkg::PROD_W-2:0], 1'b0} + addend;
                b_reg   <= {b_reg[vlt_pkg::RATE_W-2:0], 1'b0};
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == vlt_pkg::MCNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign prod = acc_reg;

endmodule

// ===== design/vlt_slot_store.sv =====
// voice slot memory with per-slot valid bits and registered read
module vlt_slot_store (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  vlt_pkg::vlt_slot_wr_t         wr,
    input  logic                          rd_en,
    input  logic [vlt_pkg::SLOT_W-1:0]    rd_addr,
    output vlt_pkg::vlt_slot_rd_t         rd
);

    logic [vlt_pkg::HANDLE_W-1:0] handle_mem [vlt_pkg::VOICE_SLOTS];
    logic [vlt_pkg::END_W-1:0]    end_mem    [vlt_pkg::VOICE_SLOTS];
    logic                         stop_mem   [vlt_pkg::VOICE_SLOTS];
    logic [vlt_pkg::VOICE_SLOTS-1:0] valid_reg;

    logic [vlt_pkg::HANDLE_W-1:0] handle_q;
    logic [vlt_pkg::END_W-1:0]    end_q;
    logic                         stop_q;
    logic                         valid_q;

    always_ff @(posedge aclk) begin
        if (wr.entry) begin
            handle_mem[wr.addr] <= wr.handle;
            end_mem[wr.addr]    <= wr.expiry;
        end
        if (wr.entry || wr.stop) begin
            stop_mem[wr.addr] <= wr.stop;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (wr.entry) begin
            valid_reg[wr.addr] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            handle_q <= handle_mem[rd_addr];
            end_q    <= end_mem[rd_addr];
            stop_q   <= stop_mem[rd_addr];
            valid_q  <= valid_reg[rd_addr];
        end
    end

    // slot never written reads as cleared
    assign rd.handle  = valid_q ? handle_q : '0;
    assign rd.expiry  = valid_q ? end_q : '0;
    assign rd.stopped = valid_q && stop_q;

endmodule

// ===== design/voice_lifetime_tracker.sv =====
// top level of the voice lifetime tracker: handle issue, duration and slot lookup
//
// channel   dir  payload
// s_        in   tuser: cmd[1:0]; tdata: handle, sound_length, pitch, now_tick
// m_        out  tdata: new_handle, playing
// cfg_wr_   in   tick_rate, 10 bits, write only
//
// start beat: runs the serial divider (23 steps by pitch, 20 by 11025)
// and the 10-step serial multiplier by tick_rate
// stop and query beats: run the 31-step serial slot-index remainder
// one beat at a time; a finished result waits in the output register while the next
// beat is taken; slot valid bits clear in the reset cycle, no clearing pass
`include "voice_lifetime_tracker_macros.svh"

module voice_lifetime_tracker (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [1:0]                     s_tuser,    // cmd
    input  logic [87:0]                    s_tdata,    // handle, sound_length, pitch, now_tick
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [31:0]                    m_tdata,    // new_handle, playing
    input  logic                           cfg_wr_en,
    input  logic [vlt_pkg::RATE_W-1:0]     cfg_wr_data
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOAD,
        ST_DIV_LEN,
        ST_MUL,
        ST_ADD,
        ST_DIV_RATE,
        ST_MOD,
        ST_READ,
        ST_RESULT
    } state_t;

    state_t                         state_reg;
    logic [vlt_pkg::CMD_W-1:0]      cmd_reg;
    logic [vlt_pkg::HANDLE_W-1:0]   handle_reg;
    logic [vlt_pkg::LEN_W-1:0]      samples_reg;
    logic [vlt_pkg::PITCH_W-1:0]    divisor_reg;
    logic [vlt_pkg::TICK_W-1:0]     now_reg;
    logic [vlt_pkg::HANDLE_W-1:0]   issued_reg;
    logic [vlt_pkg::SLOT_W-1:0]     slot_reg;
    logic [vlt_pkg::HANDLE_W-1:0]   handle_ctr_reg;
    logic [vlt_pkg::SLOT_W-1:0]     slot_ctr_reg;
    logic [vlt_pkg::RATE_W-1:0]     tick_rate_reg;
    logic [vlt_pkg::PROD_W-1:0]     t_reg;
    logic [vlt_pkg::HANDLE_W-1:0]   res_handle_reg;
    logic                           res_playing_reg;
    logic                           m_tvalid_reg;
    logic [31:0]                    m_tdata_reg;

    logic [vlt_pkg::HANDLE_W-1:0]   in_handle;
    logic [vlt_pkg::LEN_W-1:0]      in_len;
    logic [vlt_pkg::PITCH_W-1:0]    in_pitch;
    logic [vlt_pkg::TICK_W-1:0]     in_now;
    logic                           s_accept;
    logic [vlt_pkg::HANDLE_W-1:0]   hc_inc;

    logic                           div_start;
    vlt_pkg::vlt_div_req_t          div_req;
    logic                           div_busy;
    logic                           div_done;
    logic [vlt_pkg::DVD_W-1:0]      div_q;
    logic [vlt_pkg::REM_W-1:0]      div_rem;

    logic                           mul_start;
    logic                           mul_done;
    logic [vlt_pkg::PROD_W-1:0]     mul_prod;

    vlt_pkg::vlt_slot_wr_t          slot_wr;
    logic                           slot_rd_en;
    vlt_pkg::vlt_slot_rd_t          slot_rd;
    logic                           slot_match;

    assign in_handle = s_tdata[30:0];
    assign in_len    = s_tdata[46:31];
    assign in_pitch  = s_tdata[54:47];
    assign in_now    = s_tdata[85:55];

    assign s_tready  = (state_reg == ST_IDLE);
    assign s_accept  = s_tvalid && s_tready;
    assign hc_inc    = handle_ctr_reg + 1'b1;

    // divider and multiplier requests
    always_comb begin
        div_start = 1'b0;
        div_req   = '0;
        mul_start = 1'b0;
        unique case (state_reg)
            ST_LOAD: begin
                div_start = 1'b1;
                if (cmd_reg == vlt_pkg::CMD_START) begin
                    div_req.dividend = {samples_reg, (vlt_pkg::DVD_W-vlt_pkg::LEN_W)'(0)};
                    div_req.divisor  = vlt_pkg::REM_W'(divisor_reg);
                    div_req.steps    = vlt_pkg::CNT_W'(vlt_pkg::SCALED_W);
                end else begin
                    div_req.dividend = {handle_reg,
                                        (vlt_pkg::DVD_W-vlt_pkg::HANDLE_W)'(0)};
                    div_req.divisor  = vlt_pkg::REM_W'(vlt_pkg::VOICE_SLOTS);
                    div_req.steps    = vlt_pkg::CNT_W'(vlt_pkg::HANDLE_W);
                end
            end
            ST_DIV_LEN: begin
                mul_start = div_done;
            end
            ST_ADD: begin
                div_start        = 1'b1;
                div_req.dividend = {t_reg[vlt_pkg::QT_W-1:0],
                                    (vlt_pkg::DVD_W-vlt_pkg::QT_W)'(0)};
                div_req.rem_init = vlt_pkg::REM_W'(t_reg[vlt_pkg::PROD_W-1:vlt_pkg::QT_W]);
                div_req.divisor  = vlt_pkg::REM_W'(vlt_pkg::SAMPLE_RATE);
                div_req.steps    = vlt_pkg::CNT_W'(vlt_pkg::QT_W);
            end
            default: begin
            end
        endcase
    end

    // slot store access
    assign slot_match = (slot_rd.handle == handle_reg);

    always_comb begin
        slot_wr          = '0;
        slot_wr.addr     = slot_reg;
        slot_wr.handle   = issued_reg;
        slot_wr.expiry   = vlt_pkg::END_W'(now_reg)
                         + vlt_pkg::END_W'(div_q[vlt_pkg::QT_W-1:0]);
        slot_rd_en       = 1'b0;
        if (state_reg == ST_DIV_RATE && div_done) begin
            slot_wr.entry = 1'b1;
        end
        if (state_reg == ST_READ && cmd_reg == vlt_pkg::CMD_STOP && slot_match) begin
            slot_wr.stop = 1'b1;
        end
        if (state_reg == ST_MOD && div_done) begin
            slot_rd_en = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            handle_ctr_reg <= vlt_pkg::HANDLE_W'(1);
            slot_ctr_reg   <= vlt_pkg::SLOT_W'(1);
            tick_rate_reg  <= vlt_pkg::RATE_W'(vlt_pkg::RATE_RESET);
            m_tvalid_reg   <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                tick_rate_reg <= cfg_wr_data;
            end
            if (m_tvalid_reg && m_tready && state_reg != ST_RESULT) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_accept) begin
                        cmd_reg         <= s_tuser;
                        handle_reg      <= in_handle;
                        now_reg         <= in_now;
                        res_handle_reg  <= (s_tuser == vlt_pkg::CMD_START) ? handle_ctr_reg
                                                                           : '0;
                        res_playing_reg <= 1'b0;
                        samples_reg     <= (in_len > vlt_pkg::LEN_W'(vlt_pkg::HEADER_BYTES))
                                         ? in_len - vlt_pkg::LEN_W'(vlt_pkg::HEADER_BYTES)
                                         : '0;
                        divisor_reg     <= (in_pitch == '0) ? vlt_pkg::PITCH_W'(1) : in_pitch;
                        unique case (s_tuser)
                            vlt_pkg::CMD_START: begin
                                issued_reg     <= handle_ctr_reg;
                                slot_reg       <= slot_ctr_reg;
                                if (hc_inc == '0) begin
                                    handle_ctr_reg <= vlt_pkg::HANDLE_W'(1);
                                    slot_ctr_reg   <= vlt_pkg::SLOT_W'(1);
                                end else begin
                                    handle_ctr_reg <= hc_inc;
                                    slot_ctr_reg   <= (slot_ctr_reg ==
                                                       vlt_pkg::SLOT_W'(vlt_pkg::VOICE_SLOTS-1))
                                                    ? '0 : slot_ctr_reg + 1'b1;
                                end
                                state_reg <= ST_LOAD;
                            end
                            vlt_pkg::CMD_STOP, vlt_pkg::CMD_QUERY: begin
                                state_reg <= ST_LOAD;
                            end
                            default: begin
                                state_reg <= ST_RESULT;
                            end
                        endcase
                    end
                end
                ST_LOAD: begin
                    state_reg <= (cmd_reg == vlt_pkg::CMD_START) ? ST_DIV_LEN : ST_MOD;
                end
                ST_DIV_LEN: begin
                    if (div_done) begin
                        state_reg <= ST_MUL;
                    end
                end
                ST_MUL: begin
                    if (mul_done) begin
                        t_reg     <= mul_prod + vlt_pkg::PROD_W'(vlt_pkg::SAMPLE_RATE - 1);
                        state_reg <= ST_ADD;
                    end
                end
                ST_ADD: begin
                    state_reg <= ST_DIV_RATE;
                end
                ST_DIV_RATE: begin
                    if (div_done) begin
                        state_reg <= ST_RESULT;
                    end
                end
                ST_MOD: begin
                    if (div_done) begin
                        slot_reg  <= div_rem[vlt_pkg::SLOT_W-1:0];
                        state_reg <= ST_READ;
                    end
                end
                ST_READ: begin
                    res_playing_reg <= (cmd_reg == vlt_pkg::CMD_QUERY) && slot_match
                                     && !slot_rd.stopped
                                     && ({1'b0, now_reg} < slot_rd.expiry);
                    state_reg <= ST_RESULT;
                end
                ST_RESULT: begin
                    if (!m_tvalid_reg || m_tready) begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= {res_playing_reg, res_handle_reg};
                        state_reg    <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    vlt_serial_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .req     (div_req),
        .busy    (div_busy),
        .done    (div_done),
        .dvd     (div_q),
        .rem     (div_rem)
    );

    vlt_serial_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .a       (div_q[vlt_pkg::SCALED_W-1:0]),
        .b       (tick_rate_reg),
        .done    (mul_done),
        .prod    (mul_prod)
    );

    vlt_slot_store u_store (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr      (slot_wr),
        .rd_en   (slot_rd_en),
        .rd_addr (div_rem[vlt_pkg::SLOT_W-1:0]),
        .rd      (slot_rd)
    );

    `VLT_ASSERT(a_idle_div_quiet, s_tready |-> !div_busy, "beat taken while divider busy")
    `VLT_ASSERT(a_accept_leaves_idle, s_accept |=> !s_tready, "ready held after accept")
    `VLT_NEVER(a_handle_ctr_zero, handle_ctr_reg == '0, "handle counter reached zero")
    `VLT_NEVER(a_wr_rd_clash, slot_rd_en && (slot_wr.entry || slot_wr.stop), "slot clash")
    `VLT_ASSERT(a_entry_from_start, slot_wr.entry |-> cmd_reg == vlt_pkg::CMD_START, "bad entry")

endmodule
